### hw/rtl/rgbe_pkg.sv
// Package for the RGBE pixel converter: action codes and per-channel helper functions.
// Used by rgbe_pixel_convert_unit. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package rgbe_pkg;
	localparam logic ACT_ENCODE = 1'b0;
	localparam logic ACT_DECODE = 1'b1;

	// Encode one channel byte from a clean non-negative float at shared exponent e.
	function automatic logic [7:0] enc_byte(input logic [31:0] bits, input logic signed [9:0] e);
		logic [7:0]         ex;
		logic [23:0]        sig;
		logic signed [10:0] p;
		logic signed [10:0] s;
		logic [31:0]        sh;
		begin
			ex  = bits[30:23];
			sig = (ex == 8'd0) ? {1'b0, bits[22:0]} : {1'b1, bits[22:0]};
			p   = (ex == 8'd0) ? -11'sd149 : ($signed({3'b000, ex}) - 11'sd150);
			s   = p + 11'sd8 - {e[9], e};
			sh  = 32'd0;
			if (bits == 32'd0) begin
				sh = 32'd0;
			end else if (s >= 0) begin
				sh = {8'd0, sig} << s[3:0];
			end else if (s > -11'sd32) begin
				sh = {8'd0, sig} >> 5'(-s);
			end
			enc_byte = sh[7:0];
		end
	endfunction

	// Decode one mantissa byte times 2^k to float bits; k = E - 136.
	function automatic logic [31:0] dec_float(input logic [7:0] b, input logic signed [9:0] k);
		logic [3:0]         n;
		logic signed [9:0]  top;
		logic [7:0]         v;
		logic [31:0]        mant;
		logic [9:0]         bexp;
		begin
			n = 4'd0;
			v = b;
			for (int i = 0; i < 8; i++) begin
				if (b[i]) n = 4'(i + 1);
			end
			top  = $signed({6'd0, n}) - 10'sd1 + k;
			mant = ({24'd0, v} << (5'd24 - {1'b0, n})) & 32'h007F_FFFF;
			bexp = 10'(top + 10'sd127);
			if (b == 8'd0) begin
				dec_float = 32'd0;
			end else if (top >= -10'sd126) begin
				dec_float = {1'b0, bexp[7:0], mant[22:0]};
			end else begin
				dec_float = {24'd0, v} << 5'(k + 10'sd149);
			end
		end
	endfunction
endpackage
`default_nettype wire

### hw/rtl/rgbe_pixel_convert_unit.sv
// Top level of the RGBE pixel converter: input register, single-pass convert, result register.
// Depends on rgbe_pkg.
//
// One pixel per item, one item per clock while the result side does not stall. An accepted item
// is held in the stage 1 register and converted there by compare/shift logic. The result
// register captures the converted item when it is empty or being drained. With no stall on the
// result side a new item is taken on every clock. The input stalls only while stage 1 holds
// an item and a valid result waits on stall.
`timescale 1ns / 1ps
`default_nettype none
module rgbe_pixel_convert_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        action,
	input  wire logic [31:0] red_in,
	input  wire logic [31:0] green_in,
	input  wire logic [31:0] blue_in,
	input  wire logic [7:0]  shared_exponent_in,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      red_out,
	output logic [31:0]      green_out,
	output logic [31:0]      blue_out,
	output logic [7:0]       shared_exponent_out,
	output logic             out_of_range
);
	import rgbe_pkg::*;

	logic        vld_s1;
	logic        act_s1;
	logic [31:0] r_s1, g_s1, b_s1;
	logic [7:0]  e_s1;
	logic        adv_s1;
	logic        load_out;

	// Stage 1 may advance when it is empty or when output is empty or being drained
	assign load_out = ~out_valid | ~out_stall;
	assign in_stall = vld_s1 & ~load_out;
	assign adv_s1   = ~in_stall;

	// Hold input item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv_s1) begin
			vld_s1 <= in_valid;
		end
	end
	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			act_s1 <= action;
			r_s1   <= red_in;
			g_s1   <= green_in;
			b_s1   <= blue_in;
			e_s1   <= shared_exponent_in;
		end
	end

	// Convert: clean channels, find max and exponent, then encode, saturate or decode
	logic               sat;
	logic [31:0]        cr, cg, cb, mx;
	logic signed [9:0]  e;
	logic signed [9:0]  eb;
	logic [4:0]         blen;
	logic signed [9:0]  k;
	logic [31:0]        nr, ng, nb;
	logic [7:0]         ne;
	logic               nsat;

	always_comb begin
		sat = (r_s1[30:23] == 8'hFF) | (g_s1[30:23] == 8'hFF) | (b_s1[30:23] == 8'hFF);
		cr  = r_s1[31] ? 32'd0 : r_s1;
		cg  = g_s1[31] ? 32'd0 : g_s1;
		cb  = b_s1[31] ? 32'd0 : b_s1;
		mx  = (cr > cg) ? cr : cg;
		mx  = (cb > mx) ? cb : mx;
		blen = 5'd0;
		for (int i = 0; i < 23; i++) begin
			if (mx[i]) blen = 5'(i + 1);
		end
		if (mx[30:23] != 8'd0) begin
			e = $signed({2'b00, mx[30:23]}) - 10'sd126;
		end else begin
			e = $signed({5'd0, blen}) - 10'sd149;
		end
		eb = e + 10'sd128;
		k  = $signed({2'b00, e_s1}) - 10'sd136;
		nr = 32'd0; ng = 32'd0; nb = 32'd0; ne = 8'd0; nsat = 1'b0;
		if (act_s1 == ACT_DECODE) begin
			if (e_s1 != 8'd0) begin
				nr = dec_float(r_s1[7:0], k);
				ng = dec_float(g_s1[7:0], k);
				nb = dec_float(b_s1[7:0], k);
			end
		end else if (sat || (mx != 32'd0 && eb > 10'sd255)) begin
			nr = 32'd255; ng = 32'd255; nb = 32'd255; ne = 8'd255; nsat = 1'b1;
		end else if (mx != 32'd0 && eb > 10'sd0) begin
			nr = {24'd0, enc_byte(cr, e)};
			ng = {24'd0, enc_byte(cg, e)};
			nb = {24'd0, enc_byte(cb, e)};
			ne = eb[7:0];
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load_out) begin
			out_valid <= vld_s1;
		end
	end
	always_ff @(posedge clk) begin
		if (load_out && vld_s1) begin
			red_out             <= nr;
			green_out           <= ng;
			blue_out            <= nb;
			shared_exponent_out <= ne;
			out_of_range        <= nsat;
		end
	end
endmodule
`default_nettype wire

### hw/rtl/rgbe_checker.sv
// Port-level checks for rgbe_pixel_convert_unit, attached by bind.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
module rgbe_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [31:0] red_out,
	input wire logic [7:0]  shared_exponent_out,
	input wire logic        out_of_range
);
	// Stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(red_out))
		else $error("result changed under stall");
	// Saturation always gives exponent byte 255
	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_of_range |-> shared_exponent_out == 8'd255 && red_out == 32'd255)
		else $error("saturated item not all 255");
	// Input never stalls while output is free
	a_nostall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with empty output");
	// Accepted item with free path shows up at the output through stage 1 and the result register
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !out_valid |=> ##1 out_valid)
		else $error("item lost");
endmodule

bind rgbe_pixel_convert_unit rgbe_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .red_out(red_out),
	.shared_exponent_out(shared_exponent_out), .out_of_range(out_of_range)
);
`default_nettype wire
